// ===== rtl/prt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prt_pkg: shared types and constants for the packet reassembly tracker
// Status codes, controller states, the cell report struct and default sizes.
// ----------------------------------------------------------------------------
package prt_pkg;

	// default sizes handed to the top level parameters
	localparam int SLOTS_DEF         = 16;
	localparam int MAX_PACKETS_DEF   = 64;
	localparam int PAYLOAD_BYTES_DEF = 1024;

	// word layouts
	localparam int MSG_W    = 32;
	localparam int PKT_W    = 16;
	localparam int STATUS_W = 3;
	localparam int SLOTO_W  = 4;
	localparam int OFS_W    = 16;
	localparam int IN_W     = 64;
	localparam int OUT_W    = 120;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_PARTIAL = 3'd0,
		ST_DONE    = 3'd1,
		ST_DUP     = 3'd2,
		ST_FULL    = 3'd3,
		ST_BADIDX  = 3'd4
	} status_t;

	// controller states
	typedef enum logic {
		FSM_IDLE,
		FSM_EVAL
	} fsm_t;

	// what a cell tells the controller about the held header
	typedef struct packed {
		logic sel_hit;  // first matching entry in the row
		logic sel_free; // first free entry in the row
		logic bad;      // selected hit, index out of range
		logic dup;      // selected hit, packet already received
		logic done;     // this cell completes its message
	} cell_rpt_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic commit;   // apply the update at this edge
		logic any_hit;  // some entry matches the message
		logic alloc_ok; // header is fit for a new entry
	} cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/prt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prt_cell: one table entry of the reassembly row
// Holds a partial message, compares it with the broadcast header, takes part
// in the first-hit / first-free priority chain and updates itself on commit.
// ----------------------------------------------------------------------------
module prt_cell #(
	parameter int MAX_PACKETS = prt_pkg::MAX_PACKETS_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire prt_pkg::cell_ctl_t       ctl,
	input  wire [prt_pkg::MSG_W-1:0]      msg,
	input  wire [prt_pkg::PKT_W-1:0]      total,
	input  wire [prt_pkg::PKT_W-1:0]      pkt,
	input  wire                           hit_in,
	input  wire                           free_in,
	output logic                          hit_out,
	output logic                          free_out,
	output prt_pkg::cell_rpt_t            rpt
);
	import prt_pkg::*;

	localparam int TOT_W = $clog2(MAX_PACKETS + 1);
	localparam int BIT_W = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;

	logic                   valid_q;
	logic [MSG_W-1:0]       msg_q;
	logic [TOT_W-1:0]       tot_q;
	logic [MAX_PACKETS-1:0] map_q;
	logic [TOT_W-1:0]       cnt_q;

	logic                   match, is_free, sel_hit, sel_free;
	logic                   bad_local, seen, hit_act, hit_new, hit_done;
	logic                   alloc, alloc_done;
	logic [BIT_W-1:0]       bit_idx;
	logic [MAX_PACKETS-1:0] bit_oh;
	logic [TOT_W-1:0]       cnt_inc;
	logic [TOT_W-1:0]       tot_new;

	// local compare and priority chain
	always_comb begin
		match    = valid_q && (msg_q == msg);
		is_free  = !valid_q;
		sel_hit  = match && !hit_in;
		sel_free = is_free && !free_in;
		hit_out  = hit_in || match;
		free_out = free_in || is_free;
	end

	// receive-map check and update terms
	always_comb begin
		bit_idx    = pkt[BIT_W-1:0];
		bit_oh     = MAX_PACKETS'(1) << bit_idx;
		bad_local  = (pkt >= PKT_W'(tot_q)) || (pkt >= PKT_W'(MAX_PACKETS));
		seen       = |(map_q & bit_oh);
		cnt_inc    = cnt_q + TOT_W'(1);
		tot_new    = total[TOT_W-1:0];
		hit_act    = sel_hit && !bad_local;
		hit_new    = hit_act && !seen;
		hit_done   = hit_new && (cnt_inc == tot_q);
		alloc      = sel_free && !ctl.any_hit && ctl.alloc_ok;
		alloc_done = alloc && (tot_new == TOT_W'(1));
	end

	// report
	always_comb begin
		rpt.sel_hit  = sel_hit;
		rpt.sel_free = sel_free;
		rpt.bad      = sel_hit && bad_local;
		rpt.dup      = hit_act && seen;
		rpt.done     = hit_done || alloc_done;
	end

	// entry valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.commit) begin
			if (alloc) begin
				valid_q <= !alloc_done;
			end else if (hit_done) begin
				valid_q <= 1'b0;
			end
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			if (alloc) begin
				msg_q <= msg;
				tot_q <= tot_new;
				map_q <= bit_oh;
				cnt_q <= TOT_W'(1);
			end else if (hit_new) begin
				map_q <= map_q | bit_oh;
				cnt_q <= cnt_inc;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/packet_reassembly_tracker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// packet_reassembly_tracker: reassembly table for multi-packet messages
// Looks up each packet header in a row of entry cells, allocates, drops
// duplicates, counts packets and reports completion with payload offset.
// ----------------------------------------------------------------------------
//  channel  dir  word                         accepted when
//  s_axis   in   header (64 bit)              s_axis_tvalid && s_axis_tready
//  m_axis   out  result (120 bit)             m_axis_tvalid && m_axis_tready
//
// Each header is first captured in the input registers; then, in the evaluate
// state, the cell row compares, resolves first hit / first free along its chain and updates.
// The next header is taken in the cycle after the update.
// The evaluate cycle waits while the output register holds an untaken result.
// Reset clears the entry valid flags and the highest-message registers.
// ----------------------------------------------------------------------------
module packet_reassembly_tracker #(
	parameter int SLOTS         = prt_pkg::SLOTS_DEF,
	parameter int MAX_PACKETS   = prt_pkg::MAX_PACKETS_DEF,
	parameter int PAYLOAD_BYTES = prt_pkg::PAYLOAD_BYTES_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         s_axis_tvalid,
	output logic                        s_axis_tready,
	// message_number[31:0], packet_total[47:32], packet_number[63:48]
	input  wire [prt_pkg::IN_W-1:0]     s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  wire                         m_axis_tready,
	// status[2:0], echo_message[34:3], slot_used[38:35], payload_offset[54:39],
	// highest_seen_out[86:55], highest_done_out[118:87], zero[119]
	output logic [prt_pkg::OUT_W-1:0]   m_axis_tdata
);
	import prt_pkg::*;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	fsm_t              state_q, state_d;
	logic              commit;
	logic [MSG_W-1:0]  msg_q;
	logic [PKT_W-1:0]  total_q;
	logic [PKT_W-1:0]  pkt_q;
	logic [MSG_W-1:0]  hseen_q, hdone_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	cell_ctl_t         ctl;
	cell_rpt_t         rpt [SLOTS];
	logic [SLOTS:0]    hit_chain, free_chain;
	logic [SLOTS-1:0]  hit_vec, free_vec, bad_vec, dup_vec, done_vec;

	logic              any_hit, any_free, alloc_ok, alloc_take, stored;
	logic              bad_any, dup_any, done_any;
	status_t           status;
	logic [SLOTS-1:0]  slot_vec;
	logic [SLOT_W-1:0] slot_idx;
	logic [SLOT_W+SLOTO_W-1:0] slot_ext;
	logic [2*PKT_W-1:0] prod;
	logic [OFS_W-1:0]  offset;
	logic [MSG_W-1:0]  hseen_d, hdone_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: if (s_axis_tvalid) state_d = FSM_EVAL;
			FSM_EVAL: if (commit) state_d = FSM_IDLE;
			default:  state_d = FSM_IDLE;
		endcase
	end

	// controller outputs
	always_comb begin
		s_axis_tready = 1'b0;
		commit        = 1'b0;
		case (state_q)
			FSM_IDLE: s_axis_tready = 1'b1;
			FSM_EVAL: commit = !out_valid_q || m_axis_tready;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// header capture
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			msg_q   <= s_axis_tdata[31:0];
			total_q <= s_axis_tdata[47:32];
			pkt_q   <= s_axis_tdata[63:48];
		end
	end

	// broadcast to the row
	always_comb begin
		alloc_ok = (total_q != '0) && (total_q <= PKT_W'(MAX_PACKETS)) && (pkt_q < total_q);
		ctl.commit   = commit;
		ctl.any_hit  = any_hit;
		ctl.alloc_ok = alloc_ok;
	end

	// cell row
	assign hit_chain[0]  = 1'b0;
	assign free_chain[0] = 1'b0;

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		prt_cell #(
			.MAX_PACKETS(MAX_PACKETS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.msg      (msg_q),
			.total    (total_q),
			.pkt      (pkt_q),
			.hit_in   (hit_chain[g]),
			.free_in  (free_chain[g]),
			.hit_out  (hit_chain[g+1]),
			.free_out (free_chain[g+1]),
			.rpt      (rpt[g])
		);
		assign hit_vec[g]  = rpt[g].sel_hit;
		assign free_vec[g] = rpt[g].sel_free;
		assign bad_vec[g]  = rpt[g].bad;
		assign dup_vec[g]  = rpt[g].dup;
		assign done_vec[g] = rpt[g].done;
	end

	assign any_hit  = hit_chain[SLOTS];
	assign any_free = free_chain[SLOTS];

	// status decision
	always_comb begin
		bad_any    = |bad_vec;
		dup_any    = |dup_vec;
		done_any   = |done_vec;
		alloc_take = !any_hit && alloc_ok && any_free;
		if (any_hit) begin
			if (bad_any)       status = ST_BADIDX;
			else if (dup_any)  status = ST_DUP;
			else if (done_any) status = ST_DONE;
			else               status = ST_PARTIAL;
		end else begin
			if (!alloc_ok)     status = ST_BADIDX;
			else if (!any_free) status = ST_FULL;
			else if (done_any) status = ST_DONE;
			else               status = ST_PARTIAL;
		end
		stored = (status == ST_PARTIAL) || (status == ST_DONE);
	end

	// slot encode: one-hot select to index
	always_comb begin
		slot_vec = any_hit ? hit_vec : (alloc_ok ? free_vec : '0);
		slot_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_vec[i]) slot_idx = slot_idx | SLOT_W'(i);
		end
		slot_ext = {{SLOTO_W{1'b0}}, slot_idx};
	end

	// payload offset and highest tracking
	always_comb begin
		prod    = pkt_q * PKT_W'(PAYLOAD_BYTES);
		offset  = stored ? prod[OFS_W-1:0] : '0;
		hseen_d = (alloc_take && (msg_q > hseen_q)) ? msg_q : hseen_q;
		hdone_d = (done_any && (msg_q > hdone_q)) ? msg_q : hdone_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hseen_q <= '0;
			hdone_q <= '0;
		end else if (commit) begin
			hseen_q <= hseen_d;
			hdone_q <= hdone_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_data_q <= {1'b0, hdone_d, hseen_d, offset, slot_ext[SLOTO_W-1:0],
				msg_q, status};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// checks
	a_hit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> $onehot0(hit_vec))
		else $error("more than one entry selected as hit");

	a_free_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> $onehot0(free_vec))
		else $error("more than one entry selected as free");

	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q)
		else $error("commit did not load the output register");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q[STATUS_W-1:0] <= ST_BADIDX))
		else $error("result status code out of range");

	a_done_rises: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && done_any) |=> (hdone_q >= $past(msg_q)))
		else $error("highest completed message not updated");

endmodule
`default_nettype wire

// ===== tb/reassembly_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reassembly_checker: result checker for the packet reassembly tracker
// Watches both stream channels and keeps its own copy of the reassembly table.
// Each header word taken by the block yields one predicted result. Each result
// word leaving the block is compared field by field with the oldest one due.
// ----------------------------------------------------------------------------
module reassembly_checker #(
	parameter int SLOTS         = prt_pkg::SLOTS_DEF,
	parameter int MAX_PACKETS   = prt_pkg::MAX_PACKETS_DEF,
	parameter int PAYLOAD_BYTES = prt_pkg::PAYLOAD_BYTES_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        s_tvalid,
	input  wire                        s_tready,
	// message_number[31:0], packet_total[47:32], packet_number[63:48]
	input  wire [prt_pkg::IN_W-1:0]    s_tdata,
	input  wire                        m_tvalid,
	input  wire                        m_tready,
	// status[2:0], echo_message[34:3], slot_used[38:35], payload_offset[54:39],
	// highest_seen_out[86:55], highest_done_out[118:87], zero[119]
	input  wire [prt_pkg::OUT_W-1:0]   m_tdata,
	output int                         errors,
	output int                         pending
);
	import prt_pkg::*;

	typedef struct packed {
		status_t            status;
		logic [MSG_W-1:0]   msg;
		logic [SLOTO_W-1:0] slot;
		logic [OFS_W-1:0]   offset;
		logic [MSG_W-1:0]   seen;
		logic [MSG_W-1:0]   done;
	} header_result_t;

	// own copy of the reassembly table
	logic               tab_valid [SLOTS];
	logic [MSG_W-1:0]   tab_msg   [SLOTS];
	logic [6:0]         tab_total [SLOTS];
	logic [63:0]        tab_map   [SLOTS];
	logic [6:0]         tab_count [SLOTS];
	logic [MSG_W-1:0]   top_seen;
	logic [MSG_W-1:0]   top_done;

	header_result_t     due_results [$];
	header_result_t     want;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		errors++;
		if (errors <= 100)
			$display("%0t ns: %s is %h, expected %h", $time, what, got, exp_val);
	endtask

	// look the header up, update the table and return the result it causes
	function automatic header_result_t apply_header(input logic [MSG_W-1:0] msg,
			input logic [PKT_W-1:0] tot, input logic [PKT_W-1:0] pkt);
		header_result_t r;
		int             hit;
		int             vacant;
		int             idx;
		logic [31:0]    product;
		r = '0;
		r.msg = msg;
		r.status = ST_PARTIAL;
		hit = -1;
		vacant = -1;
		idx = -1;
		// first matching entry, first free entry
		for (int i = 0; i < SLOTS; i++) begin
			if (tab_valid[i]) begin
				if (hit < 0 && tab_msg[i] == msg)
					hit = i;
			end else if (vacant < 0) begin
				vacant = i;
			end
		end
		if (hit < 0) begin
			// a new message needs a usable total, an index inside it and room
			if (tot == 0 || tot > MAX_PACKETS || pkt >= tot) begin
				r.status = ST_BADIDX;
			end else if (vacant < 0) begin
				r.status = ST_FULL;
			end else begin
				idx = vacant;
				tab_valid[idx] = 1'b1;
				tab_msg[idx]   = msg;
				tab_total[idx] = tot[6:0];
				tab_map[idx]   = '0;
				tab_count[idx] = '0;
				if (msg > top_seen)
					top_seen = msg;
			end
		end else if (pkt >= tab_total[hit] || pkt >= MAX_PACKETS) begin
			// index past the stored total: entry reported, nothing changes
			r.status = ST_BADIDX;
			r.slot = SLOTO_W'(hit);
		end else begin
			idx = hit;
		end
		if (idx >= 0) begin
			r.slot = SLOTO_W'(idx);
			if (tab_map[idx][pkt[5:0]]) begin
				r.status = ST_DUP;
			end else begin
				tab_map[idx][pkt[5:0]] = 1'b1;
				tab_count[idx] = tab_count[idx] + 7'd1;
				product = 32'(pkt) * 32'(PAYLOAD_BYTES);
				r.offset = product[OFS_W-1:0];
				if (tab_count[idx] == tab_total[idx]) begin
					tab_valid[idx] = 1'b0;
					if (msg > top_done)
						top_done = msg;
					r.status = ST_DONE;
				end
			end
		end
		r.seen = top_seen;
		r.done = top_done;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				tab_valid[i] = 1'b0;
			top_seen = '0;
			top_done = '0;
			due_results.delete();
			errors = 0;
			pending = 0;
		end else begin
			// result word leaving the block
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					report_mismatch("result word with none due, echo_message",
						m_tdata[34:3], '0);
				end else begin
					want = due_results.pop_front();
					if (m_tdata[2:0] !== want.status)
						report_mismatch("status", m_tdata[2:0], want.status);
					if (m_tdata[34:3] !== want.msg)
						report_mismatch("echo_message", m_tdata[34:3], want.msg);
					if (m_tdata[38:35] !== want.slot)
						report_mismatch("slot_used", m_tdata[38:35], want.slot);
					if (m_tdata[54:39] !== want.offset)
						report_mismatch("payload_offset", m_tdata[54:39], want.offset);
					if (m_tdata[86:55] !== want.seen)
						report_mismatch("highest_seen_out", m_tdata[86:55], want.seen);
					if (m_tdata[118:87] !== want.done)
						report_mismatch("highest_done_out", m_tdata[118:87], want.done);
					if (m_tdata[119] !== 1'b0)
						report_mismatch("pad bit", m_tdata[119], '0);
				end
			end
			// header word taken by the block, queued behind those already due
			if (s_tvalid && s_tready)
				due_results.insert(due_results.size(), apply_header(s_tdata[31:0],
					s_tdata[47:32], s_tdata[63:48]));
			pending = due_results.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the packet reassembly tracker
// Sends a short directed set of headers and then random traffic that is mostly
// well-formed messages with packets out of order and repeated, mixed with
// unusable totals, out-of-range indices and attempts on a full table. Both
// sides idle at random; the checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module testbench;
	import prt_pkg::*;

	localparam int SLOTS          = SLOTS_DEF;
	localparam int MAX_PACKETS    = MAX_PACKETS_DEF;
	localparam int RANDOM_ITEMS   = 950;
	localparam int QUIET_LIMIT    = 2000;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int RX_HOLD_AFTER  = 200;

	// a message under construction, mirrors one occupied table entry
	typedef struct packed {
		logic [MSG_W-1:0] msg;
		logic [6:0]       total;
		logic [63:0]      sent;
	} open_msg_t;

	logic               clk;
	logic               arst_n;
	logic               s_axis_tvalid;
	wire                s_axis_tready;
	logic [IN_W-1:0]    s_axis_tdata;
	wire                m_axis_tvalid;
	logic               m_axis_tready;
	wire  [OUT_W-1:0]   m_axis_tdata;

	int                 chk_errors;
	int                 chk_pending;
	open_msg_t          open_msgs [$];
	logic [MSG_W-1:0]   msg_seq;
	logic               no_gaps = 1'b0;
	int                 headers_sent = 0;
	int                 msgs_built = 0;
	int                 full_tries = 0;
	int                 bad_tries = 0;
	int                 results_taken = 0;
	int                 quiet_cycles = 0;

	packet_reassembly_tracker DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	reassembly_checker u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_tdata  (s_axis_tdata),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.errors   (chk_errors),
		.pending  (chk_pending)
	);

	// 50 MHz clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// watchdog: too long without any word moving ends the run
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout after %0d quiet cycles", quiet_cycles);
			$display("[packet_reassembly_tracker] ERROR");
			$finish;
		end
	end

	// result side: random ready gaps, one long hold-off part way through
	initial begin : result_sink
		int   wait_cycles;
		logic held;
		held = 1'b0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!held && results_taken >= RX_HOLD_AFTER) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
			end
			wait_cycles = no_gaps ? 0 : $urandom_range(0, 4);
			if (wait_cycles > 0) begin
				m_axis_tready <= 1'b0;
				repeat (wait_cycles) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			results_taken++;
			@(negedge clk);
		end
	end

	// offer one header word; returns at the falling edge after it is taken
	task automatic send_header(input logic [MSG_W-1:0] msg, input logic [PKT_W-1:0] tot,
			input logic [PKT_W-1:0] pkt);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {pkt, tot, msg};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		headers_sent++;
		@(negedge clk);
	endtask

	// stop offering and wait until every result due has come out
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (chk_pending != 0) @(negedge clk);
	endtask

	// send one packet of an open message; the total is ignored on a hit
	task automatic advance_msg(input int k, input int pkt);
		logic [PKT_W-1:0] tot_field;
		logic [63:0]      all_in;
		if (open_msgs[k].sent == '0 || $urandom_range(0, 1) == 0)
			tot_field = PKT_W'(open_msgs[k].total);
		else
			tot_field = PKT_W'($urandom);
		send_header(open_msgs[k].msg, tot_field, PKT_W'(pkt));
		open_msgs[k].sent[pkt] = 1'b1;
		all_in = (open_msgs[k].total == MAX_PACKETS) ? '1 :
			(64'd1 << open_msgs[k].total) - 64'd1;
		if (open_msgs[k].sent == all_in) begin
			open_msgs.delete(k);
			msgs_built++;
		end
	endtask

	task automatic start_msg(input logic [MSG_W-1:0] msg, input int total, input int pkt);
		open_msg_t entry;
		entry = '{msg: msg, total: 7'(total), sent: '0};
		open_msgs.insert(open_msgs.size(), entry);
		advance_msg(open_msgs.size() - 1, pkt);
	endtask

	// message number not held in the table; mostly rising, now and then anywhere
	function automatic logic [MSG_W-1:0] fresh_msg();
		logic [MSG_W-1:0] m;
		logic             clash;
		do begin
			if ($urandom_range(0, 19) == 0) begin
				m = $urandom;
			end else begin
				msg_seq = msg_seq + $urandom_range(1, 1000);
				m = msg_seq;
			end
			clash = 1'b0;
			foreach (open_msgs[i])
				if (open_msgs[i].msg == m)
					clash = 1'b1;
		end while (clash);
		return m;
	endfunction

	// mostly short messages, a few up to the full size
	function automatic int draw_total();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 8);
		else if (r < 95)
			return $urandom_range(9, 32);
		return $urandom_range(33, MAX_PACKETS);
	endfunction

	// random packet of message k, already received or not
	function automatic int pick_packet(input int k, input logic got_it);
		int p;
		do
			p = $urandom_range(0, open_msgs[k].total - 1);
		while (open_msgs[k].sent[p] != got_it);
		return p;
	endfunction

	// well-formed traffic: open a message or add a packet to one, sometimes again
	task automatic wellformed_step();
		int k;
		int tot;
		if (open_msgs.size() == 0 || $urandom_range(0, 99) < 15) begin
			tot = draw_total();
			if (open_msgs.size() < SLOTS) begin
				start_msg(fresh_msg(), tot, $urandom_range(0, tot - 1));
			end else begin
				send_header(fresh_msg(), PKT_W'(tot), PKT_W'($urandom_range(0, tot - 1)));
				full_tries++;
			end
		end else begin
			k = $urandom_range(0, open_msgs.size() - 1);
			if ($urandom_range(0, 9) == 0)
				advance_msg(k, pick_packet(k, 1'b1));
			else
				advance_msg(k, pick_packet(k, 1'b0));
		end
	endtask

	// malformed headers: none of them may touch the table
	task automatic noise_step();
		int k;
		int tot;
		bad_tries++;
		case ($urandom_range(0, 2))
			0: begin
				// total unusable for a new entry
				tot = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_PACKETS + 1, 65535);
				send_header(fresh_msg(), PKT_W'(tot), PKT_W'($urandom));
			end
			1: begin
				// index past the total of a new message
				tot = $urandom_range(1, MAX_PACKETS);
				send_header(fresh_msg(), PKT_W'(tot), PKT_W'($urandom_range(tot, 65535)));
			end
			default: begin
				// index past the stored total of an open message
				if (open_msgs.size() == 0) begin
					send_header(fresh_msg(), '0, PKT_W'($urandom));
				end else begin
					k = $urandom_range(0, open_msgs.size() - 1);
					send_header(open_msgs[k].msg, PKT_W'($urandom),
						PKT_W'($urandom_range(open_msgs[k].total, 65535)));
				end
			end
		endcase
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		msg_seq = 32'h0001_0000;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// single-packet message completes at once, and again once freed
		start_msg(32'd0, 1, 0);
		start_msg(32'd0, 1, 0);
		// totals that cannot open an entry, widest fields included
		send_header(32'd7, 16'd0, 16'd0);
		send_header(32'd8, 16'(MAX_PACKETS + 1), 16'd0);
		send_header(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		bad_tries += 3;
		// full-size message: last and first packet, a repeat, an index past it
		start_msg(32'h0000_1000, MAX_PACKETS, MAX_PACKETS - 1);
		advance_msg(0, 0);
		advance_msg(0, MAX_PACKETS - 1);
		send_header(32'h0000_1000, 16'hFFFF, 16'(MAX_PACKETS));
		bad_tries++;
		// fill the remaining entries, then one message too many
		for (int i = 1; i < SLOTS; i++)
			start_msg(32'h0000_2000 + i, 2, 0);
		send_header(32'h0000_3000, 16'd2, 16'd0);
		full_tries++;
		drain();

		// random traffic; a stretch without gaps and a full drain in the middle
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 300)
				no_gaps = 1'b1;
			if (n == 450) begin
				no_gaps = 1'b0;
				drain();
			end
			if ($urandom_range(0, 99) < 80)
				wellformed_step();
			else
				noise_step();
		end

		drain();
		repeat (8) @(negedge clk);
		$display("Sent %0d headers: %0d messages reassembled, %0d tries on a full table, %0d %s",
			headers_sent, msgs_built, full_tries, bad_tries, "malformed.");
		$display("Checked %0d result words, random stalls on both sides, one %0d-cycle %s",
			results_taken, RX_HOLD_CYCLES, "hold-off.");
		if (chk_errors == 0 && chk_pending == 0)
			$display("[packet_reassembly_tracker] OK");
		else
			$display("[packet_reassembly_tracker] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/prt_pkg.sv
rtl/prt_cell.sv
rtl/packet_reassembly_tracker.sv
tb/reassembly_checker.sv
tb/testbench.sv
